// ===== hdl/ogoi_pkg.sv =====
// Shared constants for the occupancy grid obstacle inflation unit.
package ogoi_pkg;

  // Widths of the configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_CELLS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OCC_THRESH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_VALUE   = 3'd4;

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Field widths.
  localparam int unsigned SIZE_W   = 9;
  localparam int unsigned RADIUS_W = 4;
  localparam int unsigned LEVEL_W  = 7;
  localparam int unsigned COORD_W  = 8;
  localparam int unsigned CELL_W   = 8;

  // Register reset values.
  localparam logic [SIZE_W-1:0]   GRID_WIDTH_RST  = 9'd256;
  localparam logic [SIZE_W-1:0]   GRID_HEIGHT_RST = 9'd256;
  localparam logic [RADIUS_W-1:0] RADIUS_RST      = 4'd15;
  localparam logic [LEVEL_W-1:0]  THRESH_RST      = 7'd50;
  localparam logic [LEVEL_W-1:0]  MARK_RST        = 7'd99;

  // Value returned for a cell outside the grid (unknown).
  localparam logic [CELL_W-1:0] UNKNOWN_VALUE = 8'hFF;

endpackage

// ===== hdl/ogoi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ogoi_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/occupancy_grid_obstacle_inflation_unit.sv =====
// Occupancy grid store that answers reads with the obstacle-inflated value.
//
// A write beat stores one signed cell value in a single synchronous RAM;
// writes outside the configured grid are dropped. A read beat scans every cell of the
// (2r+1) x (2r+1) square around the addressed cell, one RAM read per cycle, counts those
// inside the disk and the grid as neighbors, and then reads the center cell; the input
// stays stalled from acceptance until the result is handed to the output register, as the
// single RAM read port serves the scan. A read outside the grid skips the scan and answers
// unknown. The result sits in an output register, so a new beat is taken while it waits.
// The store has no reset: read only cells that were written.
module occupancy_grid_obstacle_inflation_unit #(
  parameter int unsigned MAX_COLS   = 256,
  parameter int unsigned MAX_ROWS   = 256,
  parameter int unsigned MAX_RADIUS = 15
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [ogoi_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ogoi_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Command channel.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            command_i,
  input  logic [ogoi_pkg::COORD_W-1:0]    cell_col_i,
  input  logic [ogoi_pkg::COORD_W-1:0]    cell_row_i,
  input  logic signed [ogoi_pkg::CELL_W-1:0] cell_value_i,
  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [ogoi_pkg::CELL_W-1:0] inflated_value_o,
  output logic                            near_obstacle_o
);

  import ogoi_pkg::*;

  localparam int unsigned DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OFS_W  = RADIUS_W + 2;
  localparam int unsigned POS_W  = COORD_W + 2;
  localparam int unsigned SQ_W   = 2 * OFS_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CENTER,
    ST_LAST,
    ST_FINISH
  } state_e;

  // Configuration registers.
  logic [SIZE_W-1:0]   grid_width_q, grid_height_q;
  logic [RADIUS_W-1:0] radius_q;
  logic [LEVEL_W-1:0]  thresh_q, mark_q;

  // Sequencer and result registers.
  state_e                     state_q;
  logic [COORD_W-1:0]         col_q, row_q;
  logic signed [OFS_W-1:0]    dx_q, dy_q;
  logic                       pend_q;
  logic                       near_q;
  logic [CELL_W-1:0]          center_q;
  logic                       out_valid_q;
  logic [CELL_W-1:0]          out_value_q;
  logic                       out_near_q;

  // Effective sizes and radius after clamping.
  logic [SIZE_W-1:0]        w_eff, h_eff;
  logic [RADIUS_W-1:0]      r_eff;
  logic signed [OFS_W-1:0]  r_ofs;
  logic [SQ_W-1:0]          r_sq;

  // Scan position checks.
  logic signed [POS_W-1:0]  scan_c, scan_r;
  logic signed [SQ_W-1:0]   dx_sq, dy_sq, dist_sq;
  logic                     scan_hit;
  logic                     scan_done;
  logic                     in_accept;
  logic                     in_inside;
  logic                     out_free;

  // RAM ports.
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
  logic [CELL_W-1:0]        ram_rdata;
  logic [COORD_W-1:0]       rd_col, rd_row;

  always_comb begin
    if (grid_width_q == '0) begin
      w_eff = SIZE_W'(1);
    end else if (32'(grid_width_q) > MAX_COLS) begin
      w_eff = SIZE_W'(MAX_COLS);
    end else begin
      w_eff = grid_width_q;
    end
    if (grid_height_q == '0) begin
      h_eff = SIZE_W'(1);
    end else if (32'(grid_height_q) > MAX_ROWS) begin
      h_eff = SIZE_W'(MAX_ROWS);
    end else begin
      h_eff = grid_height_q;
    end
    r_eff = (32'(radius_q) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS) : radius_q;
  end

  assign r_ofs = $signed({2'b00, r_eff});
  assign r_sq  = SQ_W'(r_eff) * SQ_W'(r_eff);

  // Neighbor position: inside the disk and inside the grid.
  assign scan_c   = $signed({2'b00, col_q}) + POS_W'(dx_q);
  assign scan_r   = $signed({2'b00, row_q}) + POS_W'(dy_q);
  assign dx_sq    = SQ_W'(dx_q) * SQ_W'(dx_q);
  assign dy_sq    = SQ_W'(dy_q) * SQ_W'(dy_q);
  assign dist_sq  = dx_sq + dy_sq;
  assign scan_hit = (dist_sq <= $signed(r_sq))
                 && (scan_c >= 0) && (scan_c < $signed({1'b0, w_eff}))
                 && (scan_r >= 0) && (scan_r < $signed({1'b0, h_eff}));
  assign scan_done = (dx_q == r_ofs) && (dy_q == r_ofs);

  // Input handshake and grid check of the addressed cell.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_inside  = ({1'b0, cell_col_i} < w_eff) && ({1'b0, cell_row_i} < h_eff);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Writes go straight to the RAM on the accepting edge.
  assign ram_we    = in_accept && (command_i == CMD_WRITE) && in_inside;
  assign ram_waddr = ADDR_W'(cell_row_i) * ADDR_W'(MAX_COLS) + ADDR_W'(cell_col_i);

  // Read address: the scanned neighbor, or the center cell at the end.
  always_comb begin
    if (state_q == ST_SCAN) begin
      rd_col = scan_c[COORD_W-1:0];
      rd_row = scan_r[COORD_W-1:0];
    end else begin
      rd_col = col_q;
      rd_row = row_q;
    end
  end
  assign ram_raddr = ADDR_W'(rd_row) * ADDR_W'(MAX_COLS) + ADDR_W'(rd_col);

  ogoi_ram #(
    .WIDTH  (CELL_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cell_value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_WIDTH_RST;
      grid_height_q <= GRID_HEIGHT_RST;
      radius_q      <= RADIUS_RST;
      thresh_q      <= THRESH_RST;
      mark_q        <= MARK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GRID_WIDTH:   grid_width_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_GRID_HEIGHT:  grid_height_q <= cfg_data_i[SIZE_W-1:0];
        CFG_RADIUS_CELLS: radius_q      <= cfg_data_i[RADIUS_W-1:0];
        CFG_OCC_THRESH:   thresh_q      <= cfg_data_i[LEVEL_W-1:0];
        CFG_MARK_VALUE:   mark_q        <= cfg_data_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read sequencer: scan the square, then fetch the center, then hand off the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      near_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // The result register empties when the downstream side takes the beat,
      // unless a finished read refills it on the same edge.
      if (out_valid_q && !out_stall_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      // A neighbor read issued last cycle is checked against the threshold.
      if (pend_q && ($signed(ram_rdata) > $signed({1'b0, thresh_q}))) begin
        near_q <= 1'b1;
      end

      unique case (state_q)
        ST_IDLE: begin
          pend_q <= 1'b0;
          if (in_accept && (command_i == CMD_READ)) begin
            col_q  <= cell_col_i;
            row_q  <= cell_row_i;
            dx_q   <= -r_ofs;
            dy_q   <= -r_ofs;
            near_q <= 1'b0;
            if (in_inside) begin
              state_q <= ST_SCAN;
            end else begin
              center_q <= UNKNOWN_VALUE;
              state_q  <= ST_FINISH;
            end
          end
        end
        ST_SCAN: begin
          pend_q <= scan_hit;
          if (scan_done) begin
            state_q <= ST_CENTER;
          end else if (dx_q == r_ofs) begin
            dx_q <= -r_ofs;
            dy_q <= dy_q + OFS_W'(1);
          end else begin
            dx_q <= dx_q + OFS_W'(1);
          end
        end
        ST_CENTER: begin
          // Center address is on the RAM; the last neighbor is checked this cycle.
          pend_q  <= 1'b0;
          state_q <= ST_LAST;
        end
        ST_LAST: begin
          center_q <= ram_rdata;
          state_q  <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_near_q  <= near_q;
            out_value_q <= near_q ? {1'b0, mark_q} : center_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign inflated_value_o = out_value_q;
  assign near_obstacle_o  = out_near_q;

`ifndef SYNTH
  // A result that leaves the sequencer shows up as a valid beat.
  a_finish_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_free) |=> out_valid_o)
    else $error("finished read did not produce a result beat");

  // The store is written only from the idle state.
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE))
    else $error("store written while a read is in progress");

  // An accepted read always starts the sequencer.
  a_read_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && command_i == CMD_READ) |=> (state_q != ST_IDLE))
    else $error("accepted read did not start the sequencer");
`endif

endmodule

// ===== dv/ogoi_inflation_checker.sv =====
// Checker that predicts and compares the inflated read results of the grid unit.
module ogoi_inflation_checker
  import ogoi_pkg::*;
#(
  parameter int MAX_COLS   = 256,
  parameter int MAX_ROWS   = 256,
  parameter int MAX_RADIUS = 15
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic                      command_i,
  input  logic [COORD_W-1:0]        cell_col_i,
  input  logic [COORD_W-1:0]        cell_row_i,
  input  logic signed [CELL_W-1:0]  cell_value_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [CELL_W-1:0]  inflated_value_i,
  input  logic                      near_obstacle_i,
  output int                        error_count_o,
  output int                        pending_o,
  output int                        reads_checked_o,
  output int                        near_hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [CELL_W-1:0] value;
    logic                     near;
  } inflated_result_t;

  // Register copies, as the block holds them.
  logic [SIZE_W-1:0]   width_cfg;
  logic [SIZE_W-1:0]   height_cfg;
  logic [RADIUS_W-1:0] radius_cfg;
  logic [LEVEL_W-1:0]  thresh_cfg;
  logic [LEVEL_W-1:0]  mark_cfg;

  // Copy of the occupancy store, addressed row * MAX_COLS + col.
  logic signed [CELL_W-1:0] occ_shadow [MAX_COLS*MAX_ROWS];

  inflated_result_t inflated_expect_q [$];
  inflated_result_t want;

  // Grid size in use: zero counts as one, oversize saturates.
  function automatic int clamp_dim(input int size, input int limit);
    if (size < 1) return 1;
    if (size > limit) return limit;
    return size;
  endfunction

  function automatic bit in_grid(input int col, input int row);
    return col < clamp_dim(width_cfg, MAX_COLS) && row < clamp_dim(height_cfg, MAX_ROWS);
  endfunction

  // Scan the disk around the cell, clipped at the grid edges, for any obstacle.
  function automatic inflated_result_t inflate_cell(input int col, input int row);
    inflated_result_t res;
    int w, h, r, c, rr;
    w = clamp_dim(width_cfg, MAX_COLS);
    h = clamp_dim(height_cfg, MAX_ROWS);
    r = (radius_cfg > MAX_RADIUS) ? MAX_RADIUS : radius_cfg;
    res.value = UNKNOWN_VALUE;
    res.near  = 1'b0;
    if (!in_grid(col, row)) return res;
    for (int dy = -r; dy <= r; dy++) begin
      for (int dx = -r; dx <= r; dx++) begin
        c  = col + dx;
        rr = row + dy;
        if (dx * dx + dy * dy > r * r) continue;
        if (c < 0 || c >= w || rr < 0 || rr >= h) continue;
        if (int'(occ_shadow[rr*MAX_COLS+c]) > int'(thresh_cfg)) res.near = 1'b1;
      end
    end
    res.value = res.near ? {1'b0, mark_cfg} : occ_shadow[row*MAX_COLS+col];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg       = GRID_WIDTH_RST;
      height_cfg      = GRID_HEIGHT_RST;
      radius_cfg      = RADIUS_RST;
      thresh_cfg      = THRESH_RST;
      mark_cfg        = MARK_RST;
      inflated_expect_q.delete();
      error_count_o   = 0;
      pending_o       = 0;
      reads_checked_o = 0;
      near_hits_o     = 0;
    end else begin
      // Register writes keep the low bits of the data word.
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_GRID_WIDTH:   width_cfg  = cfg_data_i[SIZE_W-1:0];
          CFG_GRID_HEIGHT:  height_cfg = cfg_data_i[SIZE_W-1:0];
          CFG_RADIUS_CELLS: radius_cfg = cfg_data_i[RADIUS_W-1:0];
          CFG_OCC_THRESH:   thresh_cfg = cfg_data_i[LEVEL_W-1:0];
          CFG_MARK_VALUE:   mark_cfg   = cfg_data_i[LEVEL_W-1:0];
          default: ;
        endcase
      end

      // Result beats are matched against the oldest waiting read.
      if (out_valid_i && !out_stall_i) begin
        if (inflated_expect_q.size() == 0) begin
          $error("inflated_value: no read waiting, actual %0d", inflated_value_i);
          error_count_o++;
        end else begin
          want = inflated_expect_q.pop_front();
          reads_checked_o++;
          if (want.near) near_hits_o++;
          if (inflated_value_i !== want.value) begin
            $error("inflated_value: expected %0d, actual %0d",
                   $signed(want.value), inflated_value_i);
            error_count_o++;
          end
          if (near_obstacle_i !== want.near) begin
            $error("near_obstacle: expected %0d, actual %0d", want.near, near_obstacle_i);
            error_count_o++;
          end
        end
      end

      // Command beats: writes update the store copy, reads queue a prediction.
      if (in_valid_i && !in_stall_i) begin
        if (command_i == CMD_WRITE) begin
          if (in_grid(cell_col_i, cell_row_i))
            occ_shadow[int'(cell_row_i)*MAX_COLS+int'(cell_col_i)] = cell_value_i;
        end else begin
          inflated_expect_q.push_back(inflate_cell(cell_col_i, cell_row_i));
        end
      end
      pending_o = inflated_expect_q.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top: drives register settings and cell commands into the inflation unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ogoi_pkg::*;

  localparam int     GRID_COLS       = 256;
  localparam int     GRID_ROWS       = 256;
  localparam int     RADIUS_MAX      = 15;
  localparam int     TOTAL_BEATS     = 620;
  localparam int     SETTLE_CYCLES   = 20;
  localparam int     HOLD_OFF_CYCLES = 400;
  localparam longint TIMEOUT_NS      = 40_000_000;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic                     command;
  logic [COORD_W-1:0]       cell_col;
  logic [COORD_W-1:0]       cell_row;
  logic signed [CELL_W-1:0] cell_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [CELL_W-1:0] inflated_value;
  logic                     near_obstacle;

  int error_count;
  int pending;
  int reads_checked;
  int near_hits;

  // Cells written so far; reads are only aimed where the whole disk is written.
  bit cell_written [GRID_COLS*GRID_ROWS];
  int cur_w;
  int cur_h;
  int cur_r;
  int cur_thresh;
  int win_c0;
  int win_r0;
  int win_cols;
  int win_rows;
  int beats_sent;
  int writes_sent;
  int settings_used;
  int burst_left;
  int hold_off_req;
  bit no_gaps;

  occupancy_grid_obstacle_inflation_unit #(
    .MAX_COLS  (GRID_COLS),
    .MAX_ROWS  (GRID_ROWS),
    .MAX_RADIUS(RADIUS_MAX)
  ) u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (command),
    .cell_col_i      (cell_col),
    .cell_row_i      (cell_row),
    .cell_value_i    (cell_value),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .inflated_value_o(inflated_value),
    .near_obstacle_o (near_obstacle)
  );

  ogoi_inflation_checker #(
    .MAX_COLS  (GRID_COLS),
    .MAX_ROWS  (GRID_ROWS),
    .MAX_RADIUS(RADIUS_MAX)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .command_i       (command),
    .cell_col_i      (cell_col),
    .cell_row_i      (cell_row),
    .cell_value_i    (cell_value),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .inflated_value_i(inflated_value),
    .near_obstacle_i (near_obstacle),
    .error_count_o   (error_count),
    .pending_o       (pending),
    .reads_checked_o (reads_checked),
    .near_hits_o     (near_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[occupancy_grid_obstacle_inflation_unit] ERROR");
    $finish;
  end

  // Result side: stall modes picked at random, plus a long hold-off on request.
  initial begin
    int mode;
    int mode_left;
    out_stall = 1'b0;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req > 0) begin
        out_stall <= 1'b1;
        repeat (hold_off_req - 1) @(negedge clk);
        hold_off_req = 0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Cell values: mostly clear of the threshold, some obstacles, some unknown, some odd.
  function automatic logic [CELL_W-1:0] pick_value();
    int th;
    th = (cur_thresh > 100) ? 100 : cur_thresh;
    case ($urandom_range(0, 19))
      0, 1:    return CELL_W'($urandom_range(0, 255));
      2, 3, 4: return UNKNOWN_VALUE;
      5, 6, 7: return CELL_W'((th >= 100) ? $urandom_range(0, 100) : $urandom_range(th + 1, 100));
      default: return CELL_W'($urandom_range(0, th));
    endcase
  endfunction

  // Start of a window of the given span, biased toward the grid edges.
  function automatic int place_window(input int span, input int extent);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return extent - span;
      default: return $urandom_range(0, extent - span);
    endcase
  endfunction

  // One command beat, sent in bursts with random gaps in between.
  task automatic send_beat(input logic cmd, input int col, input int row,
                           input logic [CELL_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (no_gaps) gap = 0;
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(4, 20);
      else gap = $urandom_range(0, 3);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    command    <= cmd;
    cell_col   <= COORD_W'(col);
    cell_row   <= COORD_W'(row);
    cell_value <= val;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (cmd == CMD_WRITE) begin
      writes_sent++;
      if (col < cur_w && row < cur_h) cell_written[row*GRID_COLS+col] = 1'b1;
    end
  endtask

  // Drop valid and wait until the block has answered everything and finished any write.
  task automatic settle_block();
    @(negedge clk);
    in_valid  <= 1'b0;
    burst_left = 0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all five registers; unused upper data bits carry noise.
  task automatic apply_settings(input int w_reg, input int h_reg, input int r,
                                input int th, input int mk);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GRID_WIDTH;
    cfg_data  <= CFG_DATA_W'(w_reg);
    @(negedge clk);
    cfg_index <= CFG_GRID_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h_reg);
    @(negedge clk);
    cfg_index <= CFG_RADIUS_CELLS;
    cfg_data  <= {noise[CFG_DATA_W-1:RADIUS_W], RADIUS_W'(r)};
    @(negedge clk);
    cfg_index <= CFG_OCC_THRESH;
    cfg_data  <= {noise[CFG_DATA_W-1:LEVEL_W], LEVEL_W'(th)};
    @(negedge clk);
    cfg_index <= CFG_MARK_VALUE;
    cfg_data  <= {noise[CFG_DATA_W-2:LEVEL_W-1], LEVEL_W'(mk)};
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_w      = (w_reg < 1) ? 1 : ((w_reg > GRID_COLS) ? GRID_COLS : w_reg);
    cur_h      = (h_reg < 1) ? 1 : ((h_reg > GRID_ROWS) ? GRID_ROWS : h_reg);
    cur_r      = r;
    cur_thresh = th;
    settings_used++;
  endtask

  // Write every unwritten cell that a read inside the window can reach.
  task automatic fill_window();
    for (int rr = win_r0 - cur_r; rr < win_r0 + win_rows + cur_r; rr++) begin
      for (int cc = win_c0 - cur_r; cc < win_c0 + win_cols + cur_r; cc++) begin
        if (rr >= 0 && rr < cur_h && cc >= 0 && cc < cur_w && !cell_written[rr*GRID_COLS+cc])
          send_beat(CMD_WRITE, cc, rr, pick_value());
      end
    end
  endtask

  task automatic read_in_window();
    send_beat(CMD_READ, win_c0 + $urandom_range(0, win_cols - 1),
              win_r0 + $urandom_range(0, win_rows - 1), CELL_W'($urandom));
  endtask

  // A coordinate pair beyond the grid in use (needs a grid smaller than the maximum).
  task automatic pick_outside(output int col, output int row);
    if (cur_w < GRID_COLS && (cur_h >= GRID_ROWS || $urandom_range(0, 1) == 1)) begin
      col = $urandom_range(cur_w, GRID_COLS - 1);
      row = $urandom_range(0, GRID_ROWS - 1);
    end else begin
      col = $urandom_range(0, GRID_COLS - 1);
      row = $urandom_range(cur_h, GRID_ROWS - 1);
    end
  endtask

  initial begin
    int  phase;
    int  ops;
    int  sel;
    int  w_reg;
    int  h_reg;
    int  r;
    int  th;
    int  mk;
    int  oc;
    int  orow;
    bit  big;
    bit  can_leave;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_GRID_WIDTH;
    cfg_data      = '0;
    in_valid      = 1'b0;
    command       = CMD_WRITE;
    cell_col      = '0;
    cell_row      = '0;
    cell_value    = '0;
    beats_sent    = 0;
    writes_sent   = 0;
    settings_used = 0;
    burst_left    = 0;
    hold_off_req  = 0;
    no_gaps       = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a 3x3 grid that the largest radius covers whole.
    apply_settings(3, 3, 15, 50, 99);
    send_beat(CMD_WRITE, 0, 0, UNKNOWN_VALUE);
    send_beat(CMD_WRITE, 1, 0, 8'sd0);
    send_beat(CMD_WRITE, 2, 0, 8'sd50);
    send_beat(CMD_WRITE, 0, 1, 8'sd1);
    send_beat(CMD_WRITE, 1, 1, 8'sd0);
    send_beat(CMD_WRITE, 2, 1, 8'sd49);
    send_beat(CMD_WRITE, 0, 2, UNKNOWN_VALUE);
    send_beat(CMD_WRITE, 1, 2, 8'sd30);
    send_beat(CMD_WRITE, 2, 2, 8'sd100);
    // A value equal to the threshold is not an obstacle, but the cell at 100 is, so both reads are near one.
    send_beat(CMD_READ, 0, 0, 8'sd0);
    send_beat(CMD_READ, 2, 1, 8'sd0);
    // Reads outside the grid answer unknown.
    send_beat(CMD_READ, 255, 255, 8'sd0);
    send_beat(CMD_READ, 0, 255, 8'sd0);
    // A write beyond the grid must leave the store alone.
    send_beat(CMD_WRITE, 3, 0, 8'sd127);
    send_beat(CMD_WRITE, 0, 3, 8'sd127);
    send_beat(CMD_READ, 2, 0, 8'sd0);
    // Out-of-range stored values are compared signed.
    send_beat(CMD_WRITE, 1, 1, 8'sd127);
    send_beat(CMD_READ, 0, 0, 8'sd0);
    send_beat(CMD_WRITE, 1, 1, -8'sd128);
    send_beat(CMD_READ, 1, 1, 8'sd0);
    send_beat(CMD_WRITE, 2, 2, 8'sd51);
    send_beat(CMD_READ, 0, 0, 8'sd0);

    // Random phases, each under its own register setting.
    phase = 0;
    while (beats_sent < TOTAL_BEATS) begin
      settle_block();
      big = 1'b0;
      case (phase)
        0: begin w_reg = 8;   h_reg = 8;   r = 1;  th = 50;  mk = 99;  end
        1: begin w_reg = 256; h_reg = 256; r = 2;  th = 0;   mk = 127; big = 1'b1; end
        2: begin w_reg = 511; h_reg = 1;   r = 15; th = 127; mk = 0;   big = 1'b1; end
        3: begin w_reg = 0;   h_reg = 0;   r = 15; th = 100; mk = 100; end
        4: begin
          w_reg = 1; h_reg = 256; r = 3; big = 1'b1;
          th = $urandom_range(0, 100); mk = $urandom_range(0, 100);
        end
        default: begin
          big = ($urandom_range(0, 3) == 0);
          if (big) begin
            w_reg = $urandom_range(0, 1) ? 256 : $urandom_range(1, 511);
            h_reg = $urandom_range(0, 1) ? 256 : $urandom_range(1, 511);
            r     = $urandom_range(0, 2);
          end else begin
            w_reg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
            h_reg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
            case ($urandom_range(0, 5))
              0:       r = 0;
              1:       r = 1;
              2:       r = 2;
              3:       r = 15;
              default: r = $urandom_range(0, 15);
            endcase
          end
          case ($urandom_range(0, 9))
            0:       th = 0;
            1:       th = 127;
            2:       th = 100;
            default: th = $urandom_range(0, 100);
          endcase
          case ($urandom_range(0, 9))
            0:       mk = 0;
            1:       mk = 127;
            default: mk = $urandom_range(0, 100);
          endcase
        end
      endcase
      apply_settings(w_reg, h_reg, r, th, mk);

      // Small grids are used whole; large ones through a small window, often at an edge.
      if (big) begin
        win_cols = (cur_w < 4) ? cur_w : $urandom_range(2, 4);
        win_rows = (cur_h < 4) ? cur_h : $urandom_range(2, 4);
        win_c0   = place_window(win_cols, cur_w);
        win_r0   = place_window(win_rows, cur_h);
      end else begin
        win_c0   = 0;
        win_r0   = 0;
        win_cols = cur_w;
        win_rows = cur_h;
      end
      fill_window();
      no_gaps   = ($urandom_range(0, 3) == 0);
      can_leave = (cur_w < GRID_COLS || cur_h < GRID_ROWS);

      // Back-to-back reads against a long result hold-off fill the block up.
      if (phase == 0) begin
        no_gaps      = 1'b1;
        hold_off_req = HOLD_OFF_CYCLES;
        repeat (24) read_in_window();
        no_gaps = 1'b0;
      end

      ops = $urandom_range(20, 40);
      for (int k = 0; k < ops && beats_sent < TOTAL_BEATS; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 10 && can_leave) begin
          pick_outside(oc, orow);
          send_beat(CMD_READ, oc, orow, CELL_W'($urandom));
        end else if (sel < 20 && can_leave) begin
          pick_outside(oc, orow);
          send_beat(CMD_WRITE, oc, orow, CELL_W'($urandom));
        end else if (sel < 60) begin
          read_in_window();
        end else begin
          send_beat(CMD_WRITE, win_c0 + $urandom_range(0, win_cols - 1),
                    win_r0 + $urandom_range(0, win_rows - 1), pick_value());
        end
      end
      phase++;
    end

    settle_block();
    $display("Run covered %0d command beats (%0d writes) under %0d register settings.",
             beats_sent, writes_sent, settings_used);
    $display("Checked %0d read results, %0d of them inside an inflated obstacle.",
             reads_checked, near_hits);
    if (error_count == 0 && pending == 0) begin
      $display("[occupancy_grid_obstacle_inflation_unit] OK");
    end else begin
      $display("[occupancy_grid_obstacle_inflation_unit] ERROR");
    end
    $finish;
  end

endmodule
